// ===== rtl/md_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md_pkg
// Shared widths, reset values and controller/datapath interface types.
// ----------------------------------------------------------------------------
package md_pkg;

  localparam int unsigned ENTRY_W = 8;
  localparam int unsigned DET_W = 56;
  localparam int unsigned SIZE_W = 3;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd2;

  typedef struct packed {
    logic store_we;
    logic rd_en;
    logic mul_en;
    logic acc_clr;
    logic acc_en;
    logic acc_neg;
    logic dp_we;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } status_t;

endpackage

// ===== rtl/md_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md_ctrl
// Sequencer: loads entries, then walks row subsets and rows for the expansion.
// ----------------------------------------------------------------------------
module md_ctrl #(
  parameter int unsigned MAX_DIM = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [md_pkg::SIZE_W-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  md_pkg::status_t                 status_i,
  output md_pkg::cmd_t                    cmd_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] store_waddr_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] store_raddr_o,
  output logic [MAX_DIM-1:0]              dp_raddr_o,
  output logic [MAX_DIM-1:0]              dp_waddr_o
);

  localparam int unsigned SAW = $clog2(MAX_DIM * MAX_DIM);
  localparam int unsigned RW = $clog2(MAX_DIM);
  localparam int unsigned NW = $clog2(MAX_DIM + 1);

  localparam logic [2:0] StLoad  = 3'd0;
  localparam logic [2:0] StStart = 3'd1;
  localparam logic [2:0] StIssue = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StAcc   = 3'd4;
  localparam logic [2:0] StWrite = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [md_pkg::SIZE_W-1:0] size_q;
  logic [SAW-1:0] cnt_q, cnt_d;
  logic [MAX_DIM-1:0] s_q, s_d;
  logic [RW-1:0] r_q, r_d;
  logic neg_q, neg_d;
  logic [NW-1:0] n_eff, col;
  logic [SAW-1:0] total_m1;
  logic [MAX_DIM-1:0] full_mask;
  logic r_last, in_acc;

  always_comb begin
    if (size_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(size_q) > MAX_DIM) begin
      n_eff = NW'(MAX_DIM);
    end else begin
      n_eff = NW'(size_q);
    end
  end

  assign total_m1 = SAW'(32'(n_eff) * 32'(n_eff) - 32'd1);
  assign full_mask = MAX_DIM'((32'd1 << n_eff) - 32'd1);
  assign col = NW'(32'(n_eff) - 32'($countones(s_q)));
  assign r_last = (32'(r_q) == 32'(n_eff) - 32'd1);
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StLoad);

  assign store_waddr_o = cnt_q;
  assign store_raddr_o = SAW'(32'(r_q) * 32'(n_eff) + 32'(col));
  assign dp_raddr_o = s_q & ~(MAX_DIM'(1) << r_q);
  assign dp_waddr_o = s_q;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    s_d = s_q;
    r_d = r_q;
    neg_d = neg_q;
    cmd_o = '0;
    unique case (state_q)
      StLoad: begin
        if (in_acc) begin
          cmd_o.store_we = 1'b1;
          if (cnt_q >= total_m1) begin
            cnt_d = '0;
            s_d = MAX_DIM'(1);
            state_d = StStart;
          end else begin
            cnt_d = cnt_q + SAW'(1);
          end
        end
      end
      StStart: begin
        cmd_o.acc_clr = 1'b1;
        r_d = '0;
        neg_d = 1'b0;
        state_d = StIssue;
      end
      StIssue: begin
        cmd_o.rd_en = 1'b1;
        state_d = StMul;
      end
      StMul: begin
        cmd_o.mul_en = 1'b1;
        state_d = StAcc;
      end
      StAcc: begin
        if (s_q[r_q]) begin
          cmd_o.acc_en = 1'b1;
          cmd_o.acc_neg = neg_q;
          neg_d = !neg_q;
        end
        if (r_last) begin
          state_d = StWrite;
        end else begin
          r_d = r_q + RW'(1);
          state_d = StIssue;
        end
      end
      StWrite: begin
        cmd_o.dp_we = 1'b1;
        if (s_q == full_mask) begin
          state_d = StDone;
        end else begin
          s_d = s_q + MAX_DIM'(1);
          state_d = StStart;
        end
      end
      StDone: begin
        if (!status_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
    if (cfg_we_i) begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      size_q <= md_pkg::SIZE_RESET;
      cnt_q <= '0;
      s_q <= '0;
      r_q <= '0;
      neg_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      s_q <= s_d;
      r_q <= r_d;
      neg_q <= neg_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ===== rtl/md_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md_datapath
// Entry store, minor table, multiplier, accumulator and output register.
// ----------------------------------------------------------------------------
module md_datapath #(
  parameter int unsigned MAX_DIM = 6
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  md_pkg::cmd_t                           cmd_i,
  output md_pkg::status_t                        status_o,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     store_waddr_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     store_raddr_i,
  input  logic [MAX_DIM-1:0]                     dp_raddr_i,
  input  logic [MAX_DIM-1:0]                     dp_waddr_i,
  input  logic signed [md_pkg::ENTRY_W-1:0]      entry_value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [md_pkg::DET_W-1:0]        det_value_o
);

  localparam int unsigned STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned DP_DEPTH = 1 << MAX_DIM;
  localparam int unsigned PW = md_pkg::DET_W + md_pkg::ENTRY_W;

  logic signed [md_pkg::ENTRY_W-1:0] store_mem [STORE_DEPTH];
  logic signed [md_pkg::DET_W-1:0] dp_mem [DP_DEPTH];
  logic signed [md_pkg::ENTRY_W-1:0] entry_rd_q;
  logic signed [md_pkg::DET_W-1:0] dp_rd_q, minor;
  logic rd_zero_q;
  logic signed [PW-1:0] prod_full;
  logic signed [md_pkg::DET_W-1:0] prod_q, acc_q, det_q;
  logic out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_we) begin
      store_mem[store_waddr_i] <= entry_value_i;
    end
    if (cmd_i.rd_en) begin
      entry_rd_q <= store_mem[store_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dp_we) begin
      dp_mem[dp_waddr_i] <= acc_q;
    end
    if (cmd_i.rd_en) begin
      dp_rd_q <= dp_mem[dp_raddr_i];
      rd_zero_q <= (dp_raddr_i == '0);
    end
  end

  assign minor = rd_zero_q ? md_pkg::DET_W'(1) : dp_rd_q;
  assign prod_full = minor * entry_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_full[md_pkg::DET_W-1:0];
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= cmd_i.acc_neg ? acc_q - prod_q : acc_q + prod_q;
    end
    if (cmd_i.out_load) begin
      det_q <= acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_full = out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;
  assign det_value_o = det_q;

endmodule

// ===== rtl/matrix_determinant.sv =====
`timescale 1ns / 1ps
// Sequence: after the last entry, each row subset 1 .. 2^n - 1 runs a start state, then issue,
//   multiply and accumulate per row and a write, on one shared MAC; then the output loads.
// Throughput: entries load one per cycle, then the matrix blocks input until done.
// Reset: asynchronous active low; size returns to 2, entry count to zero.
// ----------------------------------------------------------------------------
// matrix_determinant
// Exact determinant by cofactor expansion over stored row-subset minors.
// ----------------------------------------------------------------------------
module matrix_determinant #(
  parameter int unsigned MAX_DIM = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [md_pkg::SIZE_W-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [md_pkg::ENTRY_W-1:0]  entry_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [md_pkg::DET_W-1:0]    det_value_o
);

  localparam int unsigned SAW = $clog2(MAX_DIM * MAX_DIM);

  md_pkg::cmd_t cmd;
  md_pkg::status_t status;
  logic [SAW-1:0] store_waddr, store_raddr;
  logic [MAX_DIM-1:0] dp_raddr, dp_waddr;

  md_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .status_i(status), .cmd_o(cmd),
    .store_waddr_o(store_waddr), .store_raddr_o(store_raddr),
    .dp_raddr_o(dp_raddr), .dp_waddr_o(dp_waddr)
  );

  md_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .store_waddr_i(store_waddr), .store_raddr_i(store_raddr),
    .dp_raddr_i(dp_raddr), .dp_waddr_i(dp_waddr),
    .entry_value_i, .out_valid_o, .out_stall_i, .det_value_o
  );

endmodule

// ===== rtl/md_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md_checker
// Port-level checks on transfers and result timing.
// ----------------------------------------------------------------------------
module md_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [md_pkg::DET_W-1:0]         det_value_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(det_value_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while loading");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result right after an entry transfer");

endmodule

bind matrix_determinant md_checker u_md_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .det_value_o
);
